>>> rtl/core/tzs_pkg.sv
// shared types and constants for threshold zero suppression
`timescale 1ns / 1ps

package tzs_pkg;

  localparam int SMP_W      = 12;
  localparam int TICK_W     = 12;
  localparam int THR_W      = 12;
  localparam int SUM_W      = SMP_W + 2;
  localparam int PREFIX_LEN = 4;
  localparam int PIDX_W     = $clog2(PREFIX_LEN);
  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = $clog2(OPQ_DEPTH);

  localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PREFIX_LEN - 1);

  typedef enum logic {
    OP_TEST,
    OP_FLUSH
  } op_kind_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    op_kind_t            kind;
    logic [SMP_W-1:0]    sample;
    logic [TICK_W-1:0]   tick;
    logic                kept;
    logic                step_last;
  } op_t;

endpackage

>>> rtl/core/tzs_opq.sv
// small fifo of classified ops between front and back
`timescale 1ns / 1ps

module tzs_opq import tzs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slots [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wptr;
  logic [OPQ_AW-1:0] rptr;
  logic [OPQ_AW:0]   count;

  assign full       = (count == (OPQ_AW + 1)'(OPQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= push_op;
        wptr        <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("op queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("op queue read while empty");

endmodule

>>> rtl/core/tzs_front.sv
// front: accepts samples, builds the baseline, replays the prefix and classifies
`timescale 1ns / 1ps

module tzs_front import tzs_pkg::*; #(
  parameter int ADC_BITS  = 12,
  parameter int MAX_TICKS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [THR_W-1:0] cfg_write_data,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic [SMP_W-1:0] adc_sample,
  input  logic             waveform_end,
  input  logic             q_full,
  output logic             q_push,
  output op_t              q_op
);

  localparam int CW = $clog2(MAX_TICKS);
  localparam int SW = (ADC_BITS < SMP_W) ? ADC_BITS : SMP_W;
  localparam logic [SMP_W-1:0] SMP_MASK  = SMP_W'((64'd1 << SW) - 64'd1);
  localparam logic [CW-1:0]    CNT_MAX   = CW'(MAX_TICKS - 1);
  localparam logic [CW-1:0]    CNT_PRE   = CW'(PREFIX_LEN);
  localparam logic [CW-1:0]    CNT_PLAST = CW'(PREFIX_LEN - 1);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  typedef enum logic [1:0] {
    S_ACCEPT,
    S_REPLAY,
    S_FLUSH
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [SUM_W-1:0]  sum;
  logic [THR_W-1:0]  threshold;
  logic [SMP_W-1:0]  pbuf [PREFIX_LEN];
  logic [PIDX_W-1:0] rep_idx;
  logic              rep_end;

  logic [SMP_W-1:0] x;
  logic             accept;
  logic             in_pre;
  logic [SMP_W-1:0] test_x;
  logic [SUM_W-1:0] quad;
  logic [SUM_W-1:0] dev;
  logic             kept;

  assign x            = adc_sample & SMP_MASK;
  assign sample_stall = !((state == S_ACCEPT) && !q_full);
  assign accept       = sample_valid && !sample_stall;
  assign in_pre       = (count < CNT_PRE);
  assign test_x       = (state == S_REPLAY) ? pbuf[rep_idx] : x;

  // |4x - sum| > 4*threshold
  assign quad = {test_x, 2'b00};
  assign dev  = (quad >= sum) ? (quad - sum) : (sum - quad);
  assign kept = (dev > {threshold, 2'b00});

  always_comb begin
    q_push         = 1'b0;
    q_op.kind      = OP_TEST;
    q_op.sample    = test_x;
    q_op.tick      = TICK_W'(count);
    q_op.kept      = kept;
    q_op.step_last = !waveform_end;
    unique case (state)
      S_ACCEPT: begin
        q_push = accept && !in_pre;
      end
      S_REPLAY: begin
        q_push         = !q_full;
        q_op.tick      = TICK_W'(rep_idx);
        q_op.step_last = (rep_idx == PIDX_LAST) && !rep_end;
      end
      S_FLUSH: begin
        q_push         = !q_full;
        q_op.kind      = OP_FLUSH;
        q_op.sample    = '0;
        q_op.tick      = '0;
        q_op.kept      = 1'b0;
        q_op.step_last = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCEPT;
      count     <= '0;
      sum       <= '0;
      threshold <= THR_RESET;
      rep_idx   <= '0;
      rep_end   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        threshold <= cfg_write_data;
      end
      unique case (state)
        S_ACCEPT: begin
          if (accept) begin
            if (in_pre) begin
              pbuf[count[PIDX_W-1:0]] <= x;
              sum <= (count == '0) ? SUM_W'(x) : sum + SUM_W'(x);
              if (count == CNT_PLAST) begin
                state   <= S_REPLAY;
                rep_idx <= '0;
                rep_end <= waveform_end;
              end
            end else if (waveform_end) begin
              state <= S_FLUSH;
            end
            if (waveform_end) begin
              count <= '0;
            end else if (count < CNT_MAX) begin
              count <= count + 1'b1;
            end
          end
        end
        S_REPLAY: begin
          if (!q_full) begin
            rep_idx <= rep_idx + 1'b1;
            if (rep_idx == PIDX_LAST) begin
              state <= rep_end ? S_FLUSH : S_ACCEPT;
            end
          end
        end
        S_FLUSH: begin
          if (!q_full) begin
            state <= S_ACCEPT;
          end
        end
        default: begin
          state <= S_ACCEPT;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/tzs_back.sv
// back: segment tracking, held sample, result ordering and output register
`timescale 1ns / 1ps

module tzs_back import tzs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  op_t               op,
  output logic              op_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [SMP_W-1:0]  kept_sample,
  output logic [TICK_W-1:0] tick_index,
  output logic              segment_start,
  output logic              segment_end,
  output logic              run_last
);

  typedef struct packed {
    logic [SMP_W-1:0]  sample;
    logic [TICK_W-1:0] tick;
    logic              seg_start;
    logic              seg_end;
  } res_t;

  logic              held_valid;
  logic [SMP_W-1:0]  held_sample;
  logic [TICK_W-1:0] held_tick;
  logic              held_is_start;
  logic              seg_active;
  logic              tail_valid;
  res_t              tail;
  logic              close_pend;
  res_t              result;

  logic out_ready;
  logic fire_close;
  logic r_valid;
  res_t r;
  logic emit_old;
  logic t_valid;
  res_t t;
  logic keep_now;
  logic load_out;

  assign out_ready  = !result_valid || !result_stall;
  assign fire_close = close_pend && out_ready;
  assign op_pop     = !close_pend && op_valid && out_ready;
  assign keep_now   = (op.kind == OP_TEST) && op.kept;

  // the held sample leaves whenever anything follows it
  assign r_valid     = held_valid;
  assign r.sample    = held_sample;
  assign r.tick      = held_tick;
  assign r.seg_start = held_is_start;
  assign r.seg_end   = !keep_now;

  assign emit_old = r_valid && tail_valid;
  assign t_valid  = tail_valid || r_valid;
  assign t        = r_valid ? r : tail;

  // output register gets a new beat this edge
  assign load_out = fire_close || (op_pop && (emit_old || (op.step_last && t_valid)));

  assign kept_sample   = result.sample;
  assign tick_index    = result.tick;
  assign segment_start = result.seg_start;
  assign segment_end   = result.seg_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_sample   <= '0;
      held_tick     <= '0;
      held_is_start <= 1'b0;
      seg_active    <= 1'b0;
      tail_valid    <= 1'b0;
      close_pend    <= 1'b0;
      result_valid  <= 1'b0;
      run_last      <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
      if (fire_close) begin
        result       <= tail;
        run_last     <= 1'b1;
        tail_valid   <= 1'b0;
        close_pend   <= 1'b0;
      end else if (op_pop) begin
        if (keep_now) begin
          held_is_start <= !seg_active;
          held_sample   <= op.sample;
          held_tick     <= op.tick;
          held_valid    <= 1'b1;
          seg_active    <= 1'b1;
        end else begin
          held_valid <= 1'b0;
          seg_active <= 1'b0;
        end
        if (emit_old) begin
          result       <= tail;
          run_last     <= 1'b0;
        end
        if (op.step_last && t_valid) begin
          if (emit_old) begin
            tail       <= t;
            tail_valid <= 1'b1;
            close_pend <= 1'b1;
          end else begin
            result       <= t;
            run_last     <= 1'b1;
            tail_valid   <= 1'b0;
          end
        end else begin
          tail       <= t;
          tail_valid <= t_valid;
        end
      end
    end
  end

  a_close_has_tail: assert property (@(posedge clk) disable iff (rst)
    close_pend |-> tail_valid)
    else $error("close pending without a tail result");
  a_held_in_segment: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> seg_active)
    else $error("held sample outside an open segment");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (op_pop && (op.kind == OP_FLUSH)) |=> (!held_valid && !seg_active))
    else $error("flush left segment state behind");

endmodule

>>> rtl/core/threshold_zero_suppression.sv
// top level of the baseline subtracted threshold zero suppression block
`timescale 1ns / 1ps

// Zero suppression of one ADC waveform at a time. The first four samples of a
// waveform are buffered and their sum forms the baseline; once the fourth one
// arrives the four are replayed through the threshold comparator. A sample is
// kept when |4*x - sum| > 4*threshold, and kept samples leave with their tick,
// segment start and segment end flags, and run_last on the last result of each
// input beat. A segment still open when waveform_end arrives is closed there.
// Waveforms shorter than four samples give no results. Rate: one sample per
// clock from the fifth sample on while the op queue is not full; after the
// fourth sample of a waveform the input stalls for a four-op prefix replay
// through the single comparator, and after the last sample for a flush slot.
// Results of a beat come out once that beat's last op has been resolved in the
// back end. A four entry op queue between front and back absorbs output stalls.
// No clearing pass after reset; the block takes samples as soon as reset ends.

module threshold_zero_suppression import tzs_pkg::*; #(
  parameter int ADC_BITS  = 12,
  parameter int MAX_TICKS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // threshold register write
  input  logic              cfg_write_en,
  input  logic [THR_W-1:0]  cfg_write_data,
  // sample beats
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [SMP_W-1:0]  adc_sample,
  input  logic              waveform_end,
  // result beats
  output logic              result_valid,
  input  logic              result_stall,
  output logic [SMP_W-1:0]  kept_sample,
  output logic [TICK_W-1:0] tick_index,
  output logic              segment_start,
  output logic              segment_end,
  output logic              run_last
);

  // front to queue
  logic q_push;
  op_t  q_op;
  logic q_full;

  // queue to back
  logic head_valid;
  op_t  head_op;
  logic head_pop;

  // front: counter, baseline sum, prefix buffer and the threshold compare
  tzs_front #(
    .ADC_BITS  (ADC_BITS),
    .MAX_TICKS (MAX_TICKS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .adc_sample     (adc_sample),
    .waveform_end   (waveform_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (q_op)
  );

  // classified ops wait here so the front keeps going while results stall
  tzs_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // back: held sample, segment flags, run_last ordering and output register
  tzs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (head_valid),
    .op            (head_op),
    .op_pop        (head_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kept_sample   (kept_sample),
    .tick_index    (tick_index),
    .segment_start (segment_start),
    .segment_end   (segment_end),
    .run_last      (run_last)
  );

endmodule
